// ----- design/rrq_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin ready queue: shared types and constants
// Operation and status codes, slot width and the words carried between the
// cells of the link chain and the control logic.
// ----------------------------------------------------------------------------
package rrq_pkg;

   localparam int unsigned SLOT_W    = 4;
   localparam int unsigned OP_W      = 2;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned SLOTS_MAX = 1 << SLOT_W;

   localparam logic [OP_W-1:0] OP_ADMIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

   // Contents of one slot as it travels down the chain.
   typedef struct packed {
      logic              queued;
      logic [SLOT_W-1:0] next_slot;
      logic [SLOT_W-1:0] prev_slot;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [SLOT_W-1:0] value;
   } link_write_type;

   // Writes broadcast to every cell in the update cycle.
   typedef struct packed {
      link_write_type next_a;
      link_write_type next_b;
      link_write_type prev_a;
      link_write_type prev_b;
      logic              queued_en;
      logic [SLOT_W-1:0] queued_addr;
      logic              queued_value;
   } cell_write_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

endpackage

// ----- design/rrq_cell.sv -----
// ----------------------------------------------------------------------------
// Round-robin ready queue: one slot cell
// Holds the queued flag and both links of one slot, and forwards the lookup
// word to its neighbour, replacing it with its own entry on a match.
// ----------------------------------------------------------------------------
module rrq_cell
   import rrq_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] query,
   input  entry_type         chain_in,
   output entry_type         chain_out,
   input  cell_write_type    wr
);

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

   logic              queued_ff, queued_in;
   logic [SLOT_W-1:0] next_ff, next_in;
   logic [SLOT_W-1:0] prev_ff, prev_in;
   entry_type         chain_ff, chain_in_sel;

   always_comb begin
      next_in = next_ff;
      if (wr.next_a.en && wr.next_a.addr == MY_SLOT) begin
         next_in = wr.next_a.value;
      end else if (wr.next_b.en && wr.next_b.addr == MY_SLOT) begin
         next_in = wr.next_b.value;
      end

      prev_in = prev_ff;
      if (wr.prev_a.en && wr.prev_a.addr == MY_SLOT) begin
         prev_in = wr.prev_a.value;
      end else if (wr.prev_b.en && wr.prev_b.addr == MY_SLOT) begin
         prev_in = wr.prev_b.value;
      end

      queued_in = queued_ff;
      if (wr.queued_en && wr.queued_addr == MY_SLOT) begin
         queued_in = wr.queued_value;
      end

      chain_in_sel = chain_in;
      if (query == MY_SLOT) begin
         chain_in_sel.queued    = queued_ff;
         chain_in_sel.next_slot = next_ff;
         chain_in_sel.prev_slot = prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff <= 1'b0;
      end else begin
         queued_ff <= queued_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff  <= next_in;
      prev_ff  <= prev_in;
      chain_ff <= chain_in_sel;
   end

   assign chain_out = chain_ff;

endmodule

// ----- design/round_robin_ready_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Round-robin ready queue unit
// Ready queue of thread slots kept as a circular doubly linked list, spread
// over a row of slot cells.
// ----------------------------------------------------------------------------
// A request word (admit, remove, or take next and rotate) is taken when start
// is high and busy is low. Every request gives exactly one response word,
// shown for a single cycle with rsp_valid high; the receiver cannot hold it
// off, so it must capture the word in that cycle. Busy is high from after
// acceptance through the update: the lookup word travels down the chain of
// CELLS slot cells one cell per cycle, and then the link updates are applied.
// CELLS is SLOTS limited to the sixteen slots a 4-bit slot number can name.
// The response appears in the cycle after the update, and a new request may
// be accepted in that same cycle. After reset the queue is empty and the unit
// is ready at once.
// ----------------------------------------------------------------------------
module round_robin_ready_queue_unit
   import rrq_pkg::*;
#(
   parameter int unsigned SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [SLOT_W-1:0]   req_thread_slot,
   output logic                rsp_valid,
   output logic [SLOT_W-1:0]   rsp_selected_slot,
   output logic [STATUS_W-1:0] rsp_status
);

   // Slots beyond what the slot number can address would never be used.
   localparam int unsigned CELLS = (SLOTS < SLOTS_MAX) ? SLOTS : SLOTS_MAX;
   localparam int unsigned CNT_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELLS - 1);
   localparam logic [SLOT_W:0]  CELLS_EXT = (SLOT_W + 1)'(CELLS);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   query_ff, query_in;

   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic                nonempty_ff, nonempty_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   entry_type           chain [CELLS+1];
   entry_type           found;
   cell_write_type      wr;
   logic                accept;
   logic                slot_in_range;

   // The chain enters with an empty entry, so a slot without a cell reads as
   // not queued.
   assign chain[0] = '0;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      rrq_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .query     (query_ff),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .wr        (wr)
      );
   end

   assign found         = chain[CELLS];
   assign accept        = start && (state_ff == ST_IDLE);
   assign slot_in_range = {1'b0, slot_ff} < CELLS_EXT;

   // Sequencing: idle, then the lookup word walks the chain, then the update.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in    = op_ff;
      slot_in  = slot_ff;
      query_in = query_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               count_in = '0;
               op_in    = req_operation;
               slot_in  = req_thread_slot;
               // Next looks up the head, the others the named slot.
               query_in = (req_operation == OP_NEXT) ? head_ff : req_thread_slot;
            end
         end
         ST_SCAN: begin
            count_in = count_ff + CNT_W'(1);
            if (count_ff == CNT_LAST) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // List update and response, worked out from the entry the chain delivered.
   always_comb begin
      wr            = '0;
      head_in       = head_ff;
      tail_in       = tail_ff;
      nonempty_in   = nonempty_ff;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = '0;
      rsp_status_in = ST_IGNORED;

      if (state_ff == ST_APPLY) begin
         rsp_valid_in = 1'b1;
         case (op_ff)
            OP_ADMIT: begin
               // A slot already in the queue is left alone.
               if (slot_in_range && !found.queued) begin
                  rsp_status_in   = ST_DONE;
                  wr.queued_en    = 1'b1;
                  wr.queued_addr  = slot_ff;
                  wr.queued_value = 1'b1;
                  wr.next_a       = '{en: 1'b1, addr: slot_ff, value: head_ff};
                  wr.prev_a       = '{en: 1'b1, addr: slot_ff, value: tail_ff};
                  tail_in         = slot_ff;
                  if (!nonempty_ff) begin
                     // First entry links to itself.
                     wr.next_a.value = slot_ff;
                     wr.prev_a.value = slot_ff;
                     head_in         = slot_ff;
                     nonempty_in     = 1'b1;
                  end else begin
                     wr.next_b = '{en: 1'b1, addr: tail_ff, value: slot_ff};
                     wr.prev_b = '{en: 1'b1, addr: head_ff, value: slot_ff};
                  end
               end
            end
            OP_REMOVE: begin
               if (slot_in_range && found.queued) begin
                  rsp_status_in   = ST_DONE;
                  wr.queued_en    = 1'b1;
                  wr.queued_addr  = slot_ff;
                  wr.queued_value = 1'b0;
                  if (found.next_slot == slot_ff) begin
                     // Last entry leaves: the queue is empty again.
                     head_in     = '0;
                     tail_in     = '0;
                     nonempty_in = 1'b0;
                  end else begin
                     wr.next_a = '{en: 1'b1, addr: found.prev_slot,
                                   value: found.next_slot};
                     wr.prev_a = '{en: 1'b1, addr: found.next_slot,
                                   value: found.prev_slot};
                     if (head_ff == slot_ff) begin
                        head_in = found.next_slot;
                     end
                     if (tail_ff == slot_ff) begin
                        tail_in = found.prev_slot;
                     end
                  end
               end
            end
            OP_NEXT: begin
               if (!nonempty_ff) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_status_in = ST_DONE;
                  rsp_slot_in   = head_ff;
                  // Rotation of a circular list is a step of head and tail.
                  if (found.next_slot != head_ff) begin
                     head_in = found.next_slot;
                     tail_in = head_ff;
                  end
               end
            end
            default: begin
               rsp_status_in = ST_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      query_ff      <= query_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_selected_slot = rsp_slot_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ----- verif/tb_round_robin_ready_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the round-robin ready queue unit
// Drives admit, remove and next request words through the start/busy
// handshake. It first walks a directed table, then sends random words in
// bursts with random gaps. Every reply word is checked against a fixed table
// reply or a predictor of the circular list that steps with each accepted request.
// ----------------------------------------------------------------------------
module tb_round_robin_ready_queue_unit
   import rrq_pkg::*;
();

   localparam int unsigned TB_SLOTS     = 16;
   localparam int unsigned RANDOM_WORDS = 650;
   // One request holds the unit until its update is applied; the reply follows.
   localparam int unsigned TURNAROUND   = TB_SLOTS + 2;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned MAX_GAP      = 25;

   // The one operation code that the unit must ignore.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [SLOT_W-1:0]   selected_slot;
      logic [STATUS_W-1:0] status;
   } reply_type;

   // One row of the directed table. Where fixed_reply is set, the reply is
   // written into the table; otherwise the predictor supplies it.
   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [SLOT_W-1:0] thread_slot;
      logic              fixed_reply;
      reply_type         reply;
   } directed_row_type;

   localparam int unsigned DIRECTED_ROWS = 24;

   directed_row_type directed_table [DIRECTED_ROWS] = '{
      // An empty queue after reset, and the requests it must refuse.
      '{OP_NEXT,   4'd0,  1'b1, '{4'd0, ST_EMPTY}},
      '{OP_REMOVE, 4'd5,  1'b1, '{4'd0, ST_IGNORED}},
      '{OP_UNUSED, 4'd9,  1'b1, '{4'd0, ST_IGNORED}},
      // Lowest slot, then a second admission of the same slot.
      '{OP_ADMIT,  4'd0,  1'b1, '{4'd0, ST_DONE}},
      '{OP_ADMIT,  4'd0,  1'b1, '{4'd0, ST_IGNORED}},
      // Next with a single queued slot hands back that slot and stays put.
      '{OP_NEXT,   4'd7,  1'b1, '{4'd0, ST_DONE}},
      '{OP_ADMIT,  4'd15, 1'b1, '{4'd0, ST_DONE}},
      '{OP_ADMIT,  4'd5,  1'b0, '{4'd0, ST_DONE}},
      '{OP_NEXT,   4'd15, 1'b0, '{4'd0, ST_DONE}},
      '{OP_NEXT,   4'd0,  1'b0, '{4'd0, ST_DONE}},
      '{OP_REMOVE, 4'd15, 1'b0, '{4'd0, ST_DONE}},
      '{OP_REMOVE, 4'd0,  1'b0, '{4'd0, ST_DONE}},
      '{OP_NEXT,   4'd15, 1'b0, '{4'd0, ST_DONE}},
      // Removing the last queued slot empties the queue again.
      '{OP_REMOVE, 4'd5,  1'b0, '{4'd0, ST_DONE}},
      '{OP_NEXT,   4'd15, 1'b1, '{4'd0, ST_EMPTY}},
      '{OP_REMOVE, 4'd15, 1'b1, '{4'd0, ST_IGNORED}},
      // Removal at the head and at the tail of a longer list.
      '{OP_ADMIT,  4'd10, 1'b0, '{4'd0, ST_DONE}},
      '{OP_ADMIT,  4'd3,  1'b0, '{4'd0, ST_DONE}},
      '{OP_ADMIT,  4'd12, 1'b0, '{4'd0, ST_DONE}},
      '{OP_REMOVE, 4'd10, 1'b0, '{4'd0, ST_DONE}},
      '{OP_REMOVE, 4'd12, 1'b0, '{4'd0, ST_DONE}},
      '{OP_NEXT,   4'd0,  1'b0, '{4'd0, ST_DONE}},
      '{OP_REMOVE, 4'd3,  1'b0, '{4'd0, ST_DONE}},
      '{OP_UNUSED, 4'd15, 1'b1, '{4'd0, ST_IGNORED}}
   };

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_operation;
   logic [SLOT_W-1:0]   req_thread_slot;
   logic                rsp_valid;
   logic [SLOT_W-1:0]   rsp_selected_slot;
   logic [STATUS_W-1:0] rsp_status;

   // Travel alongside the request word so that the monitor knows whether a
   // reply was written into the directed table.
   logic      word_fixed_reply;
   reply_type word_reply;

   int unsigned cycle_count;
   int unsigned error_count;

   // Replies still owed by the unit, oldest first.
   reply_type awaited_replies [$];

   // The predictor's own copy of the linked list.
   logic [SLOT_W-1:0] model_succ   [TB_SLOTS];
   logic [SLOT_W-1:0] model_pred   [TB_SLOTS];
   logic              model_queued [TB_SLOTS];
   logic [SLOT_W-1:0] model_head;
   logic [SLOT_W-1:0] model_tail;
   logic              model_nonempty;

   // The stimulus side keeps its own view of which slots are queued, so that
   // its choices never depend on the order in which processes run at an edge.
   logic [TB_SLOTS-1:0] occupied;

   round_robin_ready_queue_unit #(
      .SLOTS (TB_SLOTS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_thread_slot   (req_thread_slot),
      .rsp_valid         (rsp_valid),
      .rsp_selected_slot (rsp_selected_slot),
      .rsp_status        (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one request to the predicted list and returns the reply that
   // the unit ought to give for it.
   function automatic reply_type step_ready_queue(input logic [OP_W-1:0]   op,
                                                  input logic [SLOT_W-1:0] slot);
      reply_type         r;
      logic [SLOT_W-1:0] succ_slot;
      logic [SLOT_W-1:0] pred_slot;
      r.selected_slot = '0;
      r.status        = ST_IGNORED;
      case (op)
         OP_ADMIT: begin
            if (slot < TB_SLOTS && !model_queued[slot]) begin
               if (!model_nonempty) begin
                  model_head     = slot;
                  model_tail     = slot;
                  model_succ[slot] = slot;
                  model_pred[slot] = slot;
                  model_nonempty = 1'b1;
               end else begin
                  model_succ[slot]       = model_head;
                  model_pred[slot]       = model_tail;
                  model_succ[model_tail] = slot;
                  model_pred[model_head] = slot;
                  model_tail             = slot;
               end
               model_queued[slot] = 1'b1;
               r.status = ST_DONE;
            end
         end
         OP_REMOVE: begin
            if (slot < TB_SLOTS && model_queued[slot]) begin
               succ_slot = model_succ[slot];
               pred_slot = model_pred[slot];
               if (succ_slot == slot) begin
                  model_head     = '0;
                  model_tail     = '0;
                  model_nonempty = 1'b0;
               end else begin
                  model_succ[pred_slot] = succ_slot;
                  model_pred[succ_slot] = pred_slot;
                  if (model_head == slot) begin
                     model_head = succ_slot;
                  end
                  if (model_tail == slot) begin
                     model_tail = pred_slot;
                  end
               end
               model_queued[slot] = 1'b0;
               r.status = ST_DONE;
            end
         end
         OP_NEXT: begin
            if (!model_nonempty) begin
               r.status = ST_EMPTY;
            end else begin
               // In a circular list, rotating the head to the tail is just a
               // step of both pointers.
               r.selected_slot = model_head;
               succ_slot = model_succ[model_head];
               if (succ_slot != model_head) begin
                  model_tail = model_head;
                  model_head = succ_slot;
               end
               r.status = ST_DONE;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Monitor: checks each reply word against the oldest expectation, then
   // runs the predictor for a request accepted at this same edge.
   always @(posedge clock) begin
      reply_type want;
      reply_type predicted;
      if (reset) begin
         for (int i = 0; i < TB_SLOTS; i++) begin
            model_succ[i]   = '0;
            model_pred[i]   = '0;
            model_queued[i] = 1'b0;
         end
         model_head     = '0;
         model_tail     = '0;
         model_nonempty = 1'b0;
         awaited_replies.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               $error("reply word with nothing awaited: selected_slot %0d status %0d",
                      rsp_selected_slot, rsp_status);
               error_count++;
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_selected_slot !== want.selected_slot) begin
                  $error("selected_slot: expected %0d, actual %0d",
                         want.selected_slot, rsp_selected_slot);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            // The predictor runs for table rows too, so that its state stays
            // in step with the unit.
            predicted = step_ready_queue(req_operation, req_thread_slot);
            awaited_replies.push_back(word_fixed_reply ? word_reply : predicted);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Presents one request word and holds it until the unit takes it.
   task automatic send_word(input logic [OP_W-1:0]   op,
                            input logic [SLOT_W-1:0] slot,
                            input logic              fixed,
                            input reply_type         reply);
      start            <= 1'b1;
      req_operation    <= op;
      req_thread_slot  <= slot;
      word_fixed_reply <= fixed;
      word_reply       <= reply;
      @(posedge clock);
      while (busy) @(posedge clock);
      // Whatever the outcome, an admitted slot ends up queued and a removed
      // one ends up free.
      if (slot < TB_SLOTS) begin
         if (op == OP_ADMIT) begin
            occupied[slot] = 1'b1;
         end else if (op == OP_REMOVE) begin
            occupied[slot] = 1'b0;
         end
      end
   endtask

   task automatic hold_off(input int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Picks a slot that is queued (or free, as asked) where there is one, and
   // any slot otherwise.
   function automatic logic [SLOT_W-1:0] pick_slot(input logic want_queued);
      logic [SLOT_W-1:0] candidates [TB_SLOTS];
      int unsigned       count;
      count = 0;
      for (int i = 0; i < TB_SLOTS; i++) begin
         if (occupied[i] == want_queued) begin
            candidates[count] = SLOT_W'(i);
            count++;
         end
      end
      if (count == 0) begin
         return SLOT_W'($urandom_range(0, TB_SLOTS - 1));
      end
      return candidates[$urandom_range(0, count - 1)];
   endfunction

   initial begin
      int unsigned       burst_left;
      int unsigned       roll;
      int unsigned       admit_share;
      logic              filling;
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] slot;

      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = OP_ADMIT;
      req_thread_slot  = '0;
      word_fixed_reply = 1'b0;
      word_reply       = '0;
      occupied         = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the table is walked back to back, without gaps.
      foreach (directed_table[i]) begin
         send_word(directed_table[i].operation, directed_table[i].thread_slot,
                   directed_table[i].fixed_reply, directed_table[i].reply);
      end

      // Random part. The mix leans towards filling the queue and towards
      // draining it in turn, so that long lists and the empty queue both
      // come up often. Most admits pick a free slot and most removes a queued
      // one; the rest are the refused cases.
      burst_left = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
               hold_off($urandom_range(1, MAX_GAP));
            end
         end
         burst_left--;

         filling     = ((n / 64) % 2) == 0;
         admit_share = filling ? 52 : 30;
         roll        = $urandom_range(0, 99);
         if (roll < 4) begin
            op   = OP_UNUSED;
            slot = SLOT_W'($urandom);
         end else if (roll < admit_share) begin
            op   = OP_ADMIT;
            slot = ($urandom_range(0, 3) != 0) ? pick_slot(1'b0) : SLOT_W'($urandom);
         end else if (roll < 75) begin
            op   = OP_REMOVE;
            slot = ($urandom_range(0, 4) != 0) ? pick_slot(1'b1) : SLOT_W'($urandom);
         end else begin
            op   = OP_NEXT;
            slot = SLOT_W'($urandom);
         end
         send_word(op, slot, 1'b0, '0);
      end
      start <= 1'b0;

      // Let the last replies come home, then watch a little longer for any
      // stray reply word.
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (TURNAROUND + 4) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
